// File: design/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and fixed field widths of the message sequence reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

	localparam int TASK_W      = 4;
	localparam int NUM_W       = 32;
	localparam int HANDLE_W    = 16;
	localparam int STATUS_W    = 3;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_NONE          = 3'd0,
		ST_DELIVERED     = 3'd1,
		ST_BUFFERED      = 3'd2,
		ST_NUMBERED      = 3'd3,
		ST_INDIRECT      = 3'd4,
		ST_OUT_OF_WINDOW = 3'd5,
		ST_DUPLICATE     = 3'd6,
		ST_UNSUPPORTED   = 3'd7
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DRAIN_RD,
		S_DRAIN_OUT
	} state_t;

endpackage

`default_nettype wire

// File: design/msr_if.sv
// ----------------------------------------------------------------------------
// msr_if
// Valid/ready channels carrying message requests and reorder results.
// ----------------------------------------------------------------------------
`default_nettype none

interface msr_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  src_rank;
	logic [3:0]  dst_rank;
	logic [31:0] msg_number;
	logic        numbering_used;
	logic        process_specific;
	logic        with_ordering;
	logic        rank_local;
	logic [15:0] handle;

	modport source (
		output valid, req_type, src_rank, dst_rank, msg_number, numbering_used,
		output process_specific, with_ordering, rank_local, handle,
		input  ready
	);
	modport sink (
		input  valid, req_type, src_rank, dst_rank, msg_number, numbering_used,
		input  process_specific, with_ordering, rank_local, handle,
		output ready
	);
endinterface

interface msr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] out_handle;
	logic [31:0] seq_number;
	logic        use_numbering;
	logic        last;

	modport source (
		output valid, status, out_handle, seq_number, use_numbering, last,
		input  ready
	);
	modport sink (
		input  valid, status, out_handle, seq_number, use_numbering, last,
		output ready
	);
endinterface

`default_nettype wire

// File: design/msr_ram.sv
// ----------------------------------------------------------------------------
// msr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_ram #(
	parameter  int DEPTH = 256,
	parameter  int WIDTH = 8,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/message_sequence_reorder_top.sv
// ----------------------------------------------------------------------------
// message_sequence_reorder_top
// Per task pair sequence numbering and in-order delivery of received messages.
// ----------------------------------------------------------------------------
// One request is handled at a time. For a request that yields a single result,
// the accept cycle reads the pair's row (send counter, expected counter,
// expected slot, window occupancy) from the pair memory, and the evaluation
// state decides and presents the result once the output register is free.
// Each parked successor drained after it adds a read of the handle memory and
// a state that presents the result. At most 16 results come from one
// request. A new request is taken as soon as the last result is loaded into
// the output register, even while that result still waits to be taken. Reset
// clears a valid bit per pair, so no clearing pass runs; a pair whose bit is
// clear reads as all counters zero and an empty window.
`default_nettype none

module message_sequence_reorder_top #(
	parameter int NUM_TASKS = 16,
	parameter int WINDOW    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	msr_req_if.sink      request,
	msr_rsp_if.source    result
);

	import msr_pkg::*;

	localparam int NPAIRS  = NUM_TASKS * NUM_TASKS;
	localparam int PAIR_W  = $clog2(NPAIRS);
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int HADDR_W = $clog2(NPAIRS * WINDOW);
	localparam int ROW_W   = 2 * NUM_W + SLOT_W + WINDOW;

	// reduce a task rank modulo NUM_TASKS
	function automatic logic [TASK_W-1:0] task_mod(input logic [TASK_W-1:0] v);
		logic [TASK_W-1:0] r;
		r = v;
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= NUM_TASKS) begin
				r = r - TASK_W'(NUM_TASKS);
			end
		end
		return r;
	endfunction

	// slot of expected+1, given expected and its slot
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [NUM_W-1:0] e,
			input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = '0;
		if (e != '1 && int'(s) != WINDOW - 1) begin
			r = s + SLOT_W'(1);
		end
		return r;
	endfunction

	state_t state_q, state_d;

	// request fields
	logic                recv_q, numbered_q, ps_q, ord_q, local_q;
	logic [NUM_W-1:0]    num_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PAIR_W-1:0]   pair_q, pair_d;

	// working copy of the pair row
	logic [NUM_W-1:0]    snd_q, exp_q;
	logic [SLOT_W-1:0]   eslot_q;
	logic [WINDOW-1:0]   bits_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NPAIRS-1:0]   pair_vld_q;

	// memories
	logic [ROW_W-1:0]    row_rd, row_wr;
	logic                row_wr_en;
	logic [HANDLE_W-1:0] h_rd;
	logic                h_wr_en, h_rd_en;
	logic [HADDR_W-1:0]  h_wr_addr, h_rd_addr;

	// effective row
	logic [NUM_W-1:0]    r_snd, r_exp;
	logic [SLOT_W-1:0]   r_eslot;
	logic [WINDOW-1:0]   r_bits;

	// evaluation
	logic [NUM_W-1:0]    gap;
	logic [SLOT_W:0]     park_sum;
	logic [SLOT_W-1:0]   park_slot;
	logic                accept, can_emit, emit, more;
	logic [NUM_W-1:0]    nxt_snd, nxt_exp;
	logic [SLOT_W-1:0]   nxt_eslot;
	logic [WINDOW-1:0]   nxt_bits;
	logic [CNT_W-1:0]    nxt_cnt;
	status_t             e_status;
	logic [HANDLE_W-1:0] e_handle;
	logic [NUM_W-1:0]    e_seq;
	logic                e_use;

	// output register
	logic                out_vld_q;
	status_t             out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [NUM_W-1:0]    out_seq_q;
	logic                out_use_q, out_last_q;

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign can_emit      = !out_vld_q || result.ready;

	assign pair_d = PAIR_W'(task_mod(request.src_rank)) * PAIR_W'(NUM_TASKS)
		+ PAIR_W'(task_mod(request.dst_rank));

	// pair row memory
	msr_ram #(.DEPTH(NPAIRS), .WIDTH(ROW_W)) u_row_ram (
		.clk     (clk),
		.wr_en   (row_wr_en),
		.wr_addr (pair_q),
		.wr_data (row_wr),
		.rd_en   (accept),
		.rd_addr (pair_d),
		.rd_data (row_rd)
	);

	// parked handle memory
	msr_ram #(.DEPTH(NPAIRS * WINDOW), .WIDTH(HANDLE_W)) u_handle_ram (
		.clk     (clk),
		.wr_en   (h_wr_en),
		.wr_addr (h_wr_addr),
		.wr_data (handle_q),
		.rd_en   (h_rd_en),
		.rd_addr (h_rd_addr),
		.rd_data (h_rd)
	);

	// unpack row, empty when pair never written
	always_comb begin
		if (pair_vld_q[pair_q]) begin
			{r_snd, r_exp, r_eslot, r_bits} = row_rd;
		end else begin
			r_snd   = '0;
			r_exp   = '0;
			r_eslot = '0;
			r_bits  = '0;
		end
	end

	// window position of a received number; a number that wrapped past zero
	// is below WINDOW and sits at its own slot
	assign gap       = num_q - r_exp;
	assign park_sum  = {1'b0, r_eslot} + (SLOT_W + 1)'(gap[SLOT_W-1:0]);
	assign park_slot = (num_q < r_exp) ? SLOT_W'(num_q) :
		((int'(park_sum) >= WINDOW) ?
		SLOT_W'(park_sum - (SLOT_W + 1)'(WINDOW)) : SLOT_W'(park_sum));

	// result and row update
	always_comb begin
		emit      = 1'b0;
		more      = 1'b0;
		e_status  = ST_NONE;
		e_handle  = handle_q;
		e_seq     = num_q;
		e_use     = 1'b1;
		nxt_snd   = snd_q;
		nxt_exp   = exp_q;
		nxt_eslot = eslot_q;
		nxt_bits  = bits_q;
		nxt_cnt   = cnt_q + CNT_W'(1);
		h_wr_en   = 1'b0;
		h_wr_addr = HADDR_W'(pair_q) * HADDR_W'(WINDOW) + HADDR_W'(park_slot);
		h_rd_en   = 1'b0;
		h_rd_addr = HADDR_W'(pair_q) * HADDR_W'(WINDOW) + HADDR_W'(eslot_q);
		unique case (state_q)
			S_EVAL: begin
				emit      = can_emit;
				nxt_snd   = r_snd;
				nxt_exp   = r_exp;
				nxt_eslot = r_eslot;
				nxt_bits  = r_bits;
				nxt_cnt   = CNT_W'(1);
				if (!recv_q) begin
					e_seq = '0;
					priority if (ps_q && !ord_q) begin
						e_status = ST_NONE;
						e_use    = 1'b0;
					end else if (ps_q) begin
						e_status = ST_UNSUPPORTED;
						e_use    = 1'b0;
					end else if (!local_q) begin
						e_status = ST_INDIRECT;
						e_use    = numbered_q;
					end else begin
						e_status = ST_NUMBERED;
						e_seq    = r_snd;
						nxt_snd  = r_snd + NUM_W'(1);
					end
				end else begin
					priority if (!numbered_q || (ps_q && !ord_q)) begin
						e_status = ST_NONE;
						e_use    = 1'b0;
					end else if (ps_q) begin
						e_status = ST_UNSUPPORTED;
					end else if (!local_q) begin
						e_status = ST_INDIRECT;
					end else if (gap == '0) begin
						e_status  = ST_DELIVERED;
						nxt_exp   = r_exp + NUM_W'(1);
						nxt_eslot = slot_inc(r_exp, r_eslot);
						more      = r_bits[nxt_eslot];
					end else if (gap[NUM_W-1]) begin
						e_status = ST_DUPLICATE;
					end else if (gap >= NUM_W'(WINDOW)) begin
						e_status = ST_OUT_OF_WINDOW;
					end else if (r_bits[park_slot]) begin
						e_status = ST_DUPLICATE;
					end else begin
						e_status            = ST_BUFFERED;
						nxt_bits[park_slot] = 1'b1;
						h_wr_en             = can_emit;
						more                = nxt_bits[r_eslot];
					end
				end
			end
			S_DRAIN_RD: begin
				h_rd_en = 1'b1;
			end
			S_DRAIN_OUT: begin
				emit              = can_emit;
				e_status          = ST_DELIVERED;
				e_handle          = h_rd;
				e_seq             = exp_q;
				nxt_exp           = exp_q + NUM_W'(1);
				nxt_eslot         = slot_inc(exp_q, eslot_q);
				nxt_bits[eslot_q] = 1'b0;
				more = (int'(nxt_cnt) < MAX_RESULTS) && nxt_bits[nxt_eslot];
			end
			default: begin
			end
		endcase
		row_wr_en = emit && !more;
		row_wr    = {nxt_snd, nxt_exp, nxt_eslot, nxt_bits};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (accept) state_d = S_EVAL;
			S_EVAL,
			S_DRAIN_OUT: if (emit) state_d = more ? S_DRAIN_RD : S_IDLE;
			S_DRAIN_RD:  state_d = S_DRAIN_OUT;
			default:     state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pair_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (row_wr_en) begin
				pair_vld_q[pair_q] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// request capture and working row
	always_ff @(posedge clk) begin
		if (accept) begin
			recv_q     <= request.req_type;
			num_q      <= request.msg_number;
			numbered_q <= request.numbering_used;
			ps_q       <= request.process_specific;
			ord_q      <= request.with_ordering;
			local_q    <= request.rank_local;
			handle_q   <= request.handle;
			pair_q     <= pair_d;
		end
		if (emit) begin
			snd_q        <= nxt_snd;
			exp_q        <= nxt_exp;
			eslot_q      <= nxt_eslot;
			bits_q       <= nxt_bits;
			cnt_q        <= nxt_cnt;
			out_status_q <= e_status;
			out_handle_q <= e_handle;
			out_seq_q    <= e_seq;
			out_use_q    <= e_use;
			out_last_q   <= !more;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.status        = out_status_q;
	assign result.out_handle    = out_handle_q;
	assign result.seq_number    = out_seq_q;
	assign result.use_numbering = out_use_q;
	assign result.last          = out_last_q;

endmodule

`default_nettype wire

// File: design/msr_checker.sv
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks on the result channel of the reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] out_handle,
	input logic [31:0] seq_number,
	input logic        use_numbering,
	input logic        last
);

	import msr_pkg::*;

	logic drain_pend_q;

	// a taken non-final result means the next one is a drained successor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_pend_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			drain_pend_q <= !last;
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(out_handle) && $stable(seq_number) && $stable(last))
		else $error("result changed while stalled");

	// only deliveries and parking can be followed by more results
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_DELIVERED || status == ST_BUFFERED)
		else $error("non-final result with wrong status");

	// successors of a run are deliveries
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drain_pend_q |-> status == ST_DELIVERED && use_numbering)
		else $error("drained result is not a delivery");

	// no-numbering results never carry numbering
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NONE |-> !use_numbering && last)
		else $error("unnumbered result flagged as numbered");

endmodule

bind message_sequence_reorder_top msr_checker u_msr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.status        (result.status),
	.out_handle    (result.out_handle),
	.seq_number    (result.seq_number),
	.use_numbering (result.use_numbering),
	.last          (result.last)
);

`default_nettype wire

// File: tb/sv/tb_msr_board.sv
// ----------------------------------------------------------------------------
// tb_msr_board
// Reorder tracker: keeps per pair counters and window slots and checks the
// result stream of the message sequence reorder block in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import msr_pkg::*;

typedef struct packed {
	logic        req_type;
	logic [3:0]  src_rank;
	logic [3:0]  dst_rank;
	logic [31:0] msg_number;
	logic        numbering_used;
	logic        process_specific;
	logic        with_ordering;
	logic        rank_local;
	logic [15:0] handle;
} msg_req_t;

typedef struct packed {
	status_t     status;
	logic [15:0] out_handle;
	logic [31:0] seq_number;
	logic        use_numbering;
	logic        last;
} msg_rsp_t;

class reorder_tracker;
	localparam int NT  = 16;
	localparam int WIN = 16;

	logic [31:0] send_cnt [NT*NT];
	logic [31:0] exp_cnt  [NT*NT];
	bit          parked   [NT*NT*WIN];
	logic [15:0] parked_h [NT*NT*WIN];
	msg_rsp_t    pending[$];
	int          errors;
	int          checked;
	int          status_seen [8];

	function new();
		foreach (send_cnt[i]) begin
			send_cnt[i] = '0;
			exp_cnt[i]  = '0;
		end
		foreach (parked[i]) parked[i] = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void push(status_t st, logic [15:0] h, logic [31:0] sq, logic u);
		msg_rsp_t r;
		r.status = st;
		r.out_handle = h;
		r.seq_number = sq;
		r.use_numbering = u;
		r.last = 0;
		pending.push_back(r);
	endfunction

	// release parked successors that are now in order, up to the result cap
	function void release_run(int pair, ref int k);
		int s;
		while (k < MAX_RESULTS) begin
			s = pair * WIN + int'(exp_cnt[pair] % WIN);
			if (!parked[s])
				break;
			push(ST_DELIVERED, parked_h[s], exp_cnt[pair], 1'b1);
			parked[s] = 0;
			exp_cnt[pair] = exp_cnt[pair] + 1;
			k++;
		end
	endfunction

	// note an accepted request and queue its expected results
	function void note_request(msg_req_t q);
		int pair;
		int k;
		int s;
		logic [31:0] gap;
		pair = int'(q.src_rank) * NT + int'(q.dst_rank);
		k = 1;
		if (!q.req_type) begin
			if (q.process_specific && !q.with_ordering)
				push(ST_NONE, q.handle, '0, 1'b0);
			else if (q.process_specific)
				push(ST_UNSUPPORTED, q.handle, '0, 1'b0);
			else if (!q.rank_local)
				push(ST_INDIRECT, q.handle, '0, q.numbering_used);
			else begin
				push(ST_NUMBERED, q.handle, send_cnt[pair], 1'b1);
				send_cnt[pair] = send_cnt[pair] + 1;
			end
		end else if (!q.numbering_used || (q.process_specific && !q.with_ordering))
			push(ST_NONE, q.handle, q.msg_number, 1'b0);
		else if (q.process_specific)
			push(ST_UNSUPPORTED, q.handle, q.msg_number, 1'b1);
		else if (!q.rank_local)
			push(ST_INDIRECT, q.handle, q.msg_number, 1'b1);
		else begin
			gap = q.msg_number - exp_cnt[pair];
			if (gap == 0) begin
				push(ST_DELIVERED, q.handle, q.msg_number, 1'b1);
				exp_cnt[pair] = exp_cnt[pair] + 1;
				release_run(pair, k);
			end else if (gap >= 32'h8000_0000)
				push(ST_DUPLICATE, q.handle, q.msg_number, 1'b1);
			else if (gap >= WIN)
				push(ST_OUT_OF_WINDOW, q.handle, q.msg_number, 1'b1);
			else begin
				s = pair * WIN + int'(q.msg_number % WIN);
				if (parked[s])
					push(ST_DUPLICATE, q.handle, q.msg_number, 1'b1);
				else begin
					parked[s] = 1;
					parked_h[s] = q.handle;
					push(ST_BUFFERED, q.handle, q.msg_number, 1'b1);
					release_run(pair, k);
				end
			end
		end
		pending[pending.size()-1].last = 1'b1;
	endfunction

	task report(string what, msg_rsp_t got, msg_rsp_t w);
		errors++;
		if (errors <= 40)
			$display("MISMATCH %s: got %0d %h %h %b %b, want %0d %h %h %b %b",
				what, got.status, got.out_handle, got.seq_number, got.use_numbering,
				got.last, w.status, w.out_handle, w.seq_number, w.use_numbering, w.last);
	endtask

	// compare one result with the oldest expectation
	task check_result(msg_rsp_t got);
		msg_rsp_t w;
		checked++;
		if (pending.size() == 0) begin
			report("unexpected result", got, got);
			return;
		end
		w = pending.pop_front();
		status_seen[w.status]++;
		if (got.status !== w.status) report("status", got, w);
		if (got.out_handle !== w.out_handle) report("out_handle", got, w);
		if (got.seq_number !== w.seq_number) report("seq_number", got, w);
		if (got.use_numbering !== w.use_numbering) report("use_numbering", got, w);
		if (got.last !== w.last) report("last", got, w);
	endtask
endclass

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives send and receive requests into the reorder block, with bursty input
// and a stalling result side, and checks every result against the tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import msr_pkg::*;

module tb_top;
	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   cycle;
	int   n_sent;
	bit   drained_ok;

	msr_req_if request ();
	msr_rsp_if result ();

	reorder_tracker board;

	message_sequence_reorder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request.sink),
		.result (result.source)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("timeout with %0d results outstanding", board.pending.size());
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stall pattern: phases of steady ready, heavy and light stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			case ((cycle / 97) % 3)
				0: result.ready <= 1'b1;
				1: result.ready <= ($urandom_range(0, 3) == 0);
				default: result.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		msg_rsp_t r;
		if (arst_n && result.valid && result.ready) begin
			r.status = status_t'(result.status);
			r.out_handle = result.out_handle;
			r.seq_number = result.seq_number;
			r.use_numbering = result.use_numbering;
			r.last = result.last;
			board.check_result(r);
		end
	end

	// present one request and wait for it to be taken
	task automatic send_req(msg_req_t q);
		request.valid            <= 1'b1;
		request.req_type         <= q.req_type;
		request.src_rank         <= q.src_rank;
		request.dst_rank         <= q.dst_rank;
		request.msg_number       <= q.msg_number;
		request.numbering_used   <= q.numbering_used;
		request.process_specific <= q.process_specific;
		request.with_ordering    <= q.with_ordering;
		request.rank_local       <= q.rank_local;
		request.handle           <= q.handle;
		do @(posedge clk); while (!request.ready);
		board.note_request(q);
		n_sent++;
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			request.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic msg_req_t mk(bit rt, int s, int d, logic [31:0] num, bit nu,
		bit ps, bit ord, bit loc, logic [15:0] h);
		msg_req_t q;
		q.req_type = rt;
		q.src_rank = s[3:0];
		q.dst_rank = d[3:0];
		q.msg_number = num;
		q.numbering_used = nu;
		q.process_specific = ps;
		q.with_ordering = ord;
		q.rank_local = loc;
		q.handle = h;
		return q;
	endfunction

	task automatic wait_empty();
		request.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// random sender gap between bursts
	task automatic maybe_gap(ref int burst);
		if (burst == 0) begin
			burst = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 6));
		end
		burst--;
	endtask

	initial begin
		msg_req_t q;
		logic [31:0] ex [8];
		logic [63:0] rnd;
		int burst;
		int p, s, d, i, j, len;
		logic [31:0] base;
		int order [16];
		int tmp;
		board = new();
		cycle = 0;
		n_sent = 0;
		burst = 0;
		arst_n = 1'b0;
		request.valid <= 1'b0;
		request.req_type <= 1'b0;
		request.src_rank <= '0;
		request.dst_rank <= '0;
		request.msg_number <= '0;
		request.numbering_used <= 1'b0;
		request.process_specific <= 1'b0;
		request.with_ordering <= 1'b0;
		request.rank_local <= 1'b0;
		request.handle <= '0;
		repeat (11) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: every send and receive kind, window edges, long drain
		send_req(mk(0, 15, 0, 32'hFFFF_FFFF, 1, 0, 0, 1, 16'hFFFF));
		send_req(mk(0, 15, 0, 0, 0, 0, 0, 1, 16'h0000));
		send_req(mk(0, 3, 4, 0, 0, 1, 0, 1, 16'h1234));
		send_req(mk(0, 3, 4, 0, 1, 1, 1, 1, 16'h2345));
		send_req(mk(0, 3, 4, 0, 1, 0, 0, 0, 16'h3456));
		send_req(mk(1, 0, 15, 32'hFFFF_FFFF, 0, 0, 0, 1, 16'hAAAA));
		send_req(mk(1, 0, 15, 5, 1, 1, 0, 1, 16'h5555));
		send_req(mk(1, 0, 15, 5, 1, 1, 1, 1, 16'h6666));
		send_req(mk(1, 0, 15, 5, 1, 0, 0, 0, 16'h7777));
		send_req(mk(1, 1, 1, 0, 1, 0, 0, 1, 16'h0101));
		send_req(mk(1, 1, 1, 0, 1, 0, 0, 1, 16'h0102));
		send_req(mk(1, 1, 1, 32'h8000_0001, 1, 0, 0, 1, 16'h0103));
		send_req(mk(1, 1, 1, 32'h8000_0000, 1, 0, 0, 1, 16'h0104));
		send_req(mk(1, 1, 1, 17, 1, 0, 0, 1, 16'h0105));
		send_req(mk(1, 1, 1, 16, 1, 0, 0, 1, 16'h0106));
		// park numbers 2..15 of pair (1,1), repeat 16 and 3 as duplicates, then the gap filler
		for (i = 2; i <= 16; i++)
			send_req(mk(1, 1, 1, i, 1, 0, 0, 1, 16'h0200 + i[15:0]));
		send_req(mk(1, 1, 1, 3, 1, 0, 0, 1, 16'h0300));
		idle_cycles(1);
		send_req(mk(1, 1, 1, 1, 1, 0, 0, 1, 16'h0301));
		wait_empty();
		// full window drains in exactly the result cap; park 18 behind 17
		send_req(mk(1, 1, 1, 18, 1, 0, 0, 1, 16'h0302));
		wait_empty();
		repeat (40) @(posedge clk);

		// random: mostly shuffled in-window sequences on a few pairs, plus noise
		for (p = 0; p < 8; p++)
			ex[p] = '0;
		while (n_sent < 180) begin
			if ($urandom_range(0, 3) == 0) begin
				rnd = {$urandom, $urandom};
				q = msg_req_t'(rnd[$bits(msg_req_t)-1:0]);
				if ($urandom_range(0, 1) == 0)
					q.msg_number = {1'($urandom_range(0, 1)), 31'd0}
						^ {28'd0, q.msg_number[3:0]};
				maybe_gap(burst);
				send_req(q);
			end else begin
				p = $urandom_range(0, 7);
				s = p;
				d = 15 - p;
				len = $urandom_range(2, 10);
				base = ex[p];
				for (i = 0; i < len; i++)
					order[i] = i;
				for (i = len - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (i = 0; i < len; i++) begin
					q = mk(1, s, d, base + order[i], 1, 0, 0, 1, 16'($urandom));
					maybe_gap(burst);
					send_req(q);
					if ($urandom_range(0, 9) == 0) begin
						maybe_gap(burst);
						send_req(mk(0, s, d, $urandom, 1'($urandom), 0, 0, 1,
							16'($urandom)));
					end
				end
				ex[p] = base + len;
			end
			if (n_sent > 120 && n_sent < 126)
				wait_empty();
		end

		wait_empty();
		repeat (60) @(posedge clk);
		$display("covered %0d requests, %0d results", n_sent, board.checked);
		$display("status counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			board.status_seen[0], board.status_seen[1], board.status_seen[2],
			board.status_seen[3], board.status_seen[4], board.status_seen[5],
			board.status_seen[6], board.status_seen[7]);
		drained_ok = (board.pending.size() == 0) && (board.errors == 0);
		if (drained_ok)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
